### hw/rtl/pict_pkg.sv
// Types and constants for the pending interrupt count table.
// No dependencies; imported by pending_interrupt_count_table_top.
`default_nettype none

package pict_pkg;

    localparam logic       CMD_POST       = 1'b0;
    localparam logic       CMD_FETCH      = 1'b1;
    localparam logic       KIND_EOI       = 1'b0;
    localparam logic       KIND_REPLY     = 1'b1;
    localparam logic [7:0] SLOT_INTERRUPT = 8'd22;
    localparam int         IRQ_OUT_W      = 9;

    typedef struct packed {
        logic        cmd;
        logic [7:0]  subtype;
        logic [15:0] irq_number;
        logic [7:0]  slot_bus;
        logic [7:0]  slot_sub_bus;
        logic [7:0]  device_id;
    } req_word_t;

    typedef struct packed {
        logic                 kind;
        logic                 found;
        logic [IRQ_OUT_W-1:0] irq_out;
        logic [7:0]           eoi_bus;
        logic [7:0]           eoi_sub_bus;
        logic [7:0]           eoi_device;
    } rsp_word_t;

endpackage

`default_nettype wire

### hw/rtl/pending_interrupt_count_table_top.sv
// Pending interrupt count table: count memory, nonzero map, fixed-priority fetch.
// Depends on pict_pkg.
//
// One word is taken at a time. A slot interrupt post with a number in range
// reads the count memory when accepted and writes it back in the next cycle
// unless the count is saturated. Other posts, and out-of-range posts (which
// load an end-of-interrupt word into the output register), end when accepted.
// A fetch picks in S_CHUNK the lowest 64-bit group of the nonzero map with a
// bit set, in S_BIT the lowest bit in that group, reads the count memory in
// S_READ and decrements and writes back in S_MOD once the output register is
// free; it ends in S_BIT when nothing is pending. The nonzero map qualifies
// every memory read, so no clearing pass is needed after reset. The output
// register holds one finished word while the next is accepted.
`default_nettype none

module pending_interrupt_count_table_top #(
    parameter int NUM_IRQS    = 512,
    parameter int COUNT_WIDTH = 16
) (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                req_valid,
    output      logic                req_stall,
    input  wire pict_pkg::req_word_t req,
    output      logic                rsp_valid,
    input  wire logic                rsp_stall,
    output      pict_pkg::rsp_word_t rsp
);
    import pict_pkg::*;

    localparam int IDX_W       = $clog2(NUM_IRQS);
    localparam int CHUNK_W     = (NUM_IRQS < 64) ? NUM_IRQS : 64;
    localparam int NUM_CHUNKS  = (NUM_IRQS + CHUNK_W - 1) / CHUNK_W;
    localparam int CHUNK_IDX_W = (NUM_CHUNKS > 1) ? $clog2(NUM_CHUNKS) : 1;
    localparam int BIT_W       = $clog2(CHUNK_W);
    localparam int PAD_W       = NUM_CHUNKS * CHUNK_W;
    localparam int TOTAL_W     = COUNT_WIDTH + IDX_W;

    typedef enum logic [4:0] {
        S_IDLE  = 5'b00001,
        S_CHUNK = 5'b00010,
        S_BIT   = 5'b00100,
        S_READ  = 5'b01000,
        S_MOD   = 5'b10000
    } state_t;

    function automatic logic [CHUNK_IDX_W-1:0] chunk_lowest(input logic [NUM_CHUNKS-1:0] v);
        logic [NUM_CHUNKS-1:0]  onehot;
        logic [CHUNK_IDX_W-1:0] idx;
        onehot = v & (~v + NUM_CHUNKS'(1));
        idx    = '0;
        for (int i = 0; i < NUM_CHUNKS; i++)
        begin
            if (onehot[i])
            begin
                idx = idx | CHUNK_IDX_W'(i);
            end
        end
        return idx;
    endfunction

    function automatic logic [BIT_W-1:0] bit_lowest(input logic [CHUNK_W-1:0] v);
        logic [CHUNK_W-1:0] onehot;
        logic [BIT_W-1:0]   idx;
        onehot = v & (~v + CHUNK_W'(1));
        idx    = '0;
        for (int i = 0; i < CHUNK_W; i++)
        begin
            if (onehot[i])
            begin
                idx = idx | BIT_W'(i);
            end
        end
        return idx;
    endfunction

    state_t                  state_reg, state_next;
    logic [NUM_IRQS-1:0]     map_reg, map_next;
    logic [TOTAL_W-1:0]      total_reg, total_next;
    logic [IDX_W-1:0]        idx_reg, idx_next;
    logic                    fetch_reg, fetch_next;
    logic [CHUNK_IDX_W-1:0]  chunk_reg, chunk_next;
    logic                    rsp_valid_reg, rsp_valid_next;
    rsp_word_t               rsp_reg, rsp_next;

    logic [COUNT_WIDTH-1:0]  mem [NUM_IRQS];
    logic [COUNT_WIDTH-1:0]  rdata_reg;

    logic                    accept;
    logic                    is_slot;
    logic                    in_range;
    logic                    eoi_case;
    logic                    rsp_free;
    logic                    rsp_load;
    logic                    rd_en;
    logic [IDX_W-1:0]        rd_addr;
    logic                    wr_en;
    logic [COUNT_WIDTH-1:0]  wdata;
    logic [COUNT_WIDTH-1:0]  cur_count;
    logic [PAD_W-1:0]        map_pad;
    logic [NUM_CHUNKS-1:0]   chunk_flags;
    logic [CHUNK_W-1:0]      bit_vec;

    assign map_pad = PAD_W'(map_reg);

    always_comb
    begin
        for (int c = 0; c < NUM_CHUNKS; c++)
        begin
            chunk_flags[c] = |map_pad[c*CHUNK_W +: CHUNK_W];
        end
    end

    assign bit_vec   = map_pad[32'(chunk_reg) * CHUNK_W +: CHUNK_W];
    assign is_slot   = (req.cmd == CMD_POST) && (req.subtype == SLOT_INTERRUPT);
    assign in_range  = {16'd0, req.irq_number} < 32'(NUM_IRQS);
    assign eoi_case  = is_slot && !in_range;
    assign rsp_free  = !rsp_valid_reg || !rsp_stall;
    assign req_stall = (state_reg != S_IDLE) || (eoi_case && !rsp_free);
    assign accept    = req_valid && !req_stall;
    assign cur_count = map_reg[idx_reg] ? rdata_reg : '0;

    always_comb
    begin
        state_next     = state_reg;
        map_next       = map_reg;
        total_next     = total_reg;
        idx_next       = idx_reg;
        fetch_next     = fetch_reg;
        chunk_next     = chunk_reg;
        rsp_valid_next = rsp_valid_reg && rsp_stall;
        rsp_next       = rsp_reg;
        rsp_load       = 1'b0;
        rd_en          = 1'b0;
        rd_addr        = idx_reg;
        wr_en          = 1'b0;
        wdata          = cur_count;

        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    fetch_next = (req.cmd == CMD_FETCH);
                    if (req.cmd == CMD_FETCH)
                    begin
                        state_next = S_CHUNK;
                    end
                    else if (is_slot && in_range)
                    begin
                        rd_en      = 1'b1;
                        rd_addr    = req.irq_number[IDX_W-1:0];
                        idx_next   = req.irq_number[IDX_W-1:0];
                        state_next = S_MOD;
                    end
                    else if (eoi_case)
                    begin
                        rsp_load             = 1'b1;
                        rsp_next             = '0;
                        rsp_next.kind        = KIND_EOI;
                        rsp_next.eoi_bus     = req.slot_bus;
                        rsp_next.eoi_sub_bus = req.slot_sub_bus;
                        rsp_next.eoi_device  = req.device_id;
                    end
                end
            end
            S_CHUNK:
            begin
                chunk_next = chunk_lowest(chunk_flags);
                state_next = S_BIT;
            end
            S_BIT:
            begin
                if (|bit_vec)
                begin
                    idx_next   = IDX_W'(32'(chunk_reg) * CHUNK_W + 32'(bit_lowest(bit_vec)));
                    state_next = S_READ;
                end
                else if (rsp_free)
                begin
                    rsp_load      = 1'b1;
                    rsp_next      = '0;
                    rsp_next.kind = KIND_REPLY;
                    state_next    = S_IDLE;
                end
            end
            S_READ:
            begin
                rd_en      = 1'b1;
                state_next = S_MOD;
            end
            S_MOD:
            begin
                if (fetch_reg)
                begin
                    if (rsp_free)
                    begin
                        wr_en             = 1'b1;
                        wdata             = cur_count - COUNT_WIDTH'(1);
                        map_next[idx_reg] = (wdata != '0);
                        if (total_reg != '0)
                        begin
                            total_next = total_reg - TOTAL_W'(1);
                        end
                        rsp_load         = 1'b1;
                        rsp_next         = '0;
                        rsp_next.kind    = KIND_REPLY;
                        rsp_next.found   = 1'b1;
                        rsp_next.irq_out = IRQ_OUT_W'(idx_reg);
                        state_next       = S_IDLE;
                    end
                end
                else
                begin
                    if (cur_count != {COUNT_WIDTH{1'b1}})
                    begin
                        wr_en             = 1'b1;
                        wdata             = cur_count + COUNT_WIDTH'(1);
                        map_next[idx_reg] = 1'b1;
                        total_next        = total_reg + TOTAL_W'(1);
                    end
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        if (rsp_load)
        begin
            rsp_valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            map_reg       <= '0;
            total_reg     <= '0;
            fetch_reg     <= 1'b0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            map_reg       <= map_next;
            total_reg     <= total_next;
            fetch_reg     <= fetch_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        idx_reg   <= idx_next;
        chunk_reg <= chunk_next;
        rsp_reg   <= rsp_next;
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[idx_reg] <= wdata;
        end
        if (rd_en)
        begin
            rdata_reg <= mem[rd_addr];
        end
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

    // total is zero exactly when no count is pending
    a_total_map: assert property (@(posedge clk) disable iff (!rst_n)
        (total_reg == '0) == (map_reg == '0))
        else $error("total and nonzero map disagree");

    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_load && rsp_valid_reg) |-> !rsp_stall)
        else $error("held output word overwritten");

    a_fetch_pending: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_MOD && fetch_reg) |-> map_reg[idx_reg])
        else $error("fetch picked an entry with zero count");

    a_read_before_mod: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_MOD && $past(state_reg) != S_MOD) |-> $past(rd_en))
        else $error("update without a memory read");

endmodule

`default_nettype wire
